FILE: hdl/rtdpf_pkg.sv
// shared constants, types and the arctangent table of the path follower
package rtdpf_pkg;

  localparam int unsigned PATH_DEPTH_DEF = 1024;

  localparam int POS_W     = 24;
  localparam int DIFF_W    = POS_W + 1;
  localparam int SQ_W      = 2 * DIFF_W + 1;
  localparam int ROOT_W    = 26;
  localparam int ACC_W     = 27;
  localparam int ANG_W     = 18;
  localparam int HD_W      = 16;
  localparam int LIN_W     = 12;
  localparam int ASPD_W    = 14;
  localparam int LOOK_W    = 16;
  localparam int ATAN_W    = 16;
  localparam int CORDIC_STEPS = 16;

  // angles in 1/8192 rad unless fine (1/65536 rad)
  localparam int PI_Q       = 25736;
  localparam int TWO_PI_Q   = 51472;
  localparam int PI_FINE    = 205887;
  localparam int START_TURN = 4096;
  localparam int STOP_TURN  = 410;
  localparam int MIN_TURN   = 819;
  localparam int SLOW_RANGE = 4915;
  localparam int TURN_CAP   = 5734;
  localparam int SLOW_SPAN  = 4505;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WALK_RD,
    ST_WALK_WAIT,
    ST_WALK_SQRT,
    ST_AIM,
    ST_ANGLE,
    ST_STEER,
    ST_MUL,
    ST_DLOAD,
    ST_DIV,
    ST_DONE
  } st_e;

  typedef enum logic [1:0] {
    REG_MAX_LIN   = 2'd0,
    REG_MAX_ANG   = 2'd1,
    REG_LOOKAHEAD = 2'd2
  } reg_e;

  // atan(2^-i) in 1/65536 rad
  function automatic logic [ATAN_W-1:0] atan_f(input logic [3:0] i);
    logic [ATAN_W-1:0] v;
    case (i)
      4'd0:    v = 16'd51472;
      4'd1:    v = 16'd30386;
      4'd2:    v = 16'd16055;
      4'd3:    v = 16'd8150;
      4'd4:    v = 16'd4091;
      4'd5:    v = 16'd2047;
      4'd6:    v = 16'd1024;
      4'd7:    v = 16'd512;
      4'd8:    v = 16'd256;
      4'd9:    v = 16'd128;
      4'd10:   v = 16'd64;
      4'd11:   v = 16'd32;
      4'd12:   v = 16'd16;
      4'd13:   v = 16'd8;
      4'd14:   v = 16'd4;
      4'd15:   v = 16'd2;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

FILE: hdl/rtdpf_store.sv
// waypoint ring memory, one write and one registered read port
module rtdpf_store import rtdpf_pkg::*; #(
  parameter int unsigned DEPTH = PATH_DEPTH_DEF,
  parameter int unsigned AW    = $clog2(PATH_DEPTH_DEF),
  parameter int unsigned DW    = 2 * POS_W
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/rtdpf_isqrt.sv
// iterative integer square root, one result bit per cycle
module rtdpf_isqrt import rtdpf_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [SQ_W-1:0]   value_i,
  output logic              done_o,
  output logic [ROOT_W-1:0] root_o
);

  localparam int RAD_W = 2 * ROOT_W;
  localparam int REM_W = ROOT_W + 2;
  localparam int CNT_W = $clog2(ROOT_W);

  logic             busy_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [RAD_W-1:0] rad_q;
  logic [REM_W-1:0] rem_q, rem_n;
  logic [ROOT_W-1:0] root_q, root_n;
  logic [REM_W+1:0] rem_t, trial;
  logic             ge;

  always_comb begin
    rem_t = {rem_q, rad_q[RAD_W-1 -: 2]};
    trial = {2'b00, root_q, 2'b01};
    ge    = rem_t >= trial;
    if (ge) begin
      rem_n  = REM_W'(rem_t - trial);
      root_n = {root_q[ROOT_W-2:0], 1'b1};
    end else begin
      rem_n  = rem_t[REM_W-1:0];
      root_n = {root_q[ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(ROOT_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= {{(RAD_W - SQ_W){1'b0}}, value_i};
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
      rem_q  <= rem_n;
      root_q <= root_n;
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

FILE: hdl/rtdpf_cordic.sv
// iterative vectoring cordic, angle of (dx, dy) in 1/8192 rad
module rtdpf_cordic import rtdpf_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic signed [DIFF_W-1:0] dx_i,
  input  logic signed [DIFF_W-1:0] dy_i,
  output logic                     done_o,
  output logic signed [ANG_W-1:0]  angle_o
);

  localparam int XY_W = DIFF_W + 3;
  localparam int Z_W  = 21;

  logic                    busy_q, done_q;
  logic [3:0]              cnt_q;
  logic signed [XY_W-1:0]  x_q, y_q, x_n, y_n, shx, shy, dx_e, dy_e;
  logic signed [Z_W-1:0]   z_q, z_n, at, zr;
  logic signed [ANG_W-1:0] ang_q, ang_fin;

  always_comb begin
    dx_e = $signed({{3{dx_i[DIFF_W-1]}}, dx_i});
    dy_e = $signed({{3{dy_i[DIFF_W-1]}}, dy_i});
    shx  = x_q >>> cnt_q;
    shy  = y_q >>> cnt_q;
    at   = $signed({{(Z_W - ATAN_W){1'b0}}, atan_f(cnt_q)});
    if (y_q > 0) begin
      x_n = x_q + shy;
      y_n = y_q - shx;
      z_n = z_q + at;
    end else begin
      x_n = x_q - shy;
      y_n = y_q + shx;
      z_n = z_q - at;
    end
    zr      = z_n + Z_W'(4);
    ang_fin = ANG_W'(zr >>> 3);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= '0;
        if (dy_i == '0) begin
          done_q <= 1'b1;
          busy_q <= 1'b0;
        end else begin
          busy_q <= 1'b1;
        end
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == 4'(CORDIC_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      if (dy_i == '0) begin
        ang_q <= (dx_i < 0) ? ANG_W'(PI_Q) : '0;
      end
      if (dx_i < 0) begin
        x_q <= -dx_e;
        y_q <= -dy_e;
        z_q <= (dy_i > 0) ? Z_W'(PI_FINE) : -Z_W'(PI_FINE);
      end else begin
        x_q <= dx_e;
        y_q <= dy_e;
        z_q <= '0;
      end
    end else if (busy_q) begin
      x_q <= x_n;
      y_q <= y_n;
      z_q <= z_n;
      if (cnt_q == 4'(CORDIC_STEPS - 1)) begin
        ang_q <= ang_fin;
      end
    end
  end

  assign done_o  = done_q;
  assign angle_o = ang_q;

endmodule

FILE: hdl/rotate_then_drive_path_follower_top.sv
// path follower top level: register port, sequencer, scan/walk datapath and steering
//
// Waypoints (op 0) are written into a ring memory; new_plan restarts the
// ring, and a waypoint arriving on a full ring is dropped. A pose (op 1)
// runs a sequence: a pipelined scan reads every stored waypoint once to
// find the nearest one, then a walk reads one waypoint per segment and
// takes its length with an iterative square root, then a 16-step cordic
// and the steering stage, which for the slowdown band adds a multiply and
// a reciprocal divide. An empty plan skips the scan and goes straight to
// the done state. The block takes one item at a time and holds off new
// input while a pose is in work; a finished command sits in an output
// register so the next transfer can be taken while it waits.
// Configuration registers sit at byte addresses 0, 4 and 8 and are
// meant to be written only while the block is idle.
module rotate_then_drive_path_follower_top import rtdpf_pkg::*; #(
  parameter int unsigned PATH_DEPTH = PATH_DEPTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // input item channel
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     op_i,
  input  logic                     new_plan_i,
  input  logic signed [POS_W-1:0]  pos_x_i,
  input  logic signed [POS_W-1:0]  pos_y_i,
  input  logic signed [HD_W-1:0]   heading_i,
  // result channel
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic                     status_o,
  output logic [LIN_W-1:0]         linear_speed_o,
  output logic signed [ASPD_W-1:0] angular_speed_o,
  output logic                     rotating_o,
  output logic signed [HD_W-1:0]   heading_error_o,
  // register port
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [3:0]               paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  localparam int unsigned AW = $clog2(PATH_DEPTH);
  localparam int unsigned CW = $clog2(PATH_DEPTH + 1);
  localparam int unsigned DW = 2 * POS_W;
  localparam int PROD_W = 29;
  localparam int DVD_W  = 26;
  localparam int REMD_W = 13;
  // 2^36 / slowdown span rounded up, exact for dividends below 2^27
  localparam int RECIP_W  = 24;
  localparam int RECIP_SH = 36;
  localparam logic [RECIP_W-1:0] RECIP = 24'd15254046;

  // ring slot of plan offset off, wraps at the ring depth
  function automatic logic [AW-1:0] slot_f(input logic [AW-1:0] base,
                                           input logic [CW-1:0] off);
    logic [CW:0] sum;
    sum = (CW+1)'(base) + (CW+1)'(off);
    if (sum >= (CW+1)'(PATH_DEPTH)) begin
      sum = sum - (CW+1)'(PATH_DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  st_e state_q, state_d;

  // configuration
  logic [LIN_W-1:0]  max_lin_q;
  logic [ASPD_W-1:0] max_ang_q;
  logic [LOOK_W-1:0] look_q;
  logic              cfg_wr;

  // plan bookkeeping and hysteresis flag
  logic [AW-1:0] start_q;
  logic [CW-1:0] count_q;
  logic          flag_q;

  // pose being served
  logic signed [POS_W-1:0] px_q, py_q;
  logic signed [HD_W-1:0]  hd_q;

  // memory ports
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [DW-1:0] mem_rdata;
  logic          in_xfer;
  logic [AW-1:0] start_eff;
  logic [CW-1:0] cnt_eff;

  // read pipeline: read data, differences, squares
  logic                     rd_v_q, d_v_q, s_v_q;
  logic [CW-1:0]            rd_idx_q, d_idx_q, s_idx_q;
  logic signed [POS_W-1:0]  rd_x, rd_y, ref_x, ref_y;
  logic signed [POS_W-1:0]  d_x_q, d_y_q, s_x_q, s_y_q;
  logic signed [DIFF_W-1:0] dx_q, dy_q;
  logic [2*DIFF_W-1:0]      sqx_q, sqy_q;
  logic [SQ_W-1:0]          dsum;

  // scan and walk
  logic [CW-1:0]           scan_i_q, walk_i_q, near_q, walk_nx;
  logic                    scan_done, walk_more;
  logic [SQ_W-1:0]         best_q;
  logic signed [POS_W-1:0] bx_q, by_q, ax_q, ay_q;
  logic [ACC_W-1:0]        acc_q, acc_sum;
  logic                    reached;

  // square root and angle units
  logic                     sqrt_start, sqrt_done;
  logic [ROOT_W-1:0]        root;
  logic                     cordic_start, cordic_done;
  logic signed [DIFF_W-1:0] tdx, tdy;
  logic signed [ANG_W-1:0]  angle;

  // steering
  logic signed [ANG_W-1:0]  raw, wrapped;
  logic [ANG_W-1:0]         err;
  logic                     flag_new, slow;
  logic [ASPD_W-1:0]        cap;
  logic [ANG_W-1:0]         err_off;
  logic [REMD_W-1:0]        n_calc, n_q;
  logic signed [ASPD_W:0]   capm, capm_q;
  logic signed [PROD_W-1:0] prod_q;
  logic                     neg_q, diff_pos_q;
  logic [DVD_W-1:0]         dvd_q, mag;
  logic [DVD_W+RECIP_W-1:0] qprod;
  logic [REMD_W-1:0]        quot;
  logic signed [ASPD_W:0]   spd;

  // result holding and output register
  logic                     res_status_q;
  logic [LIN_W-1:0]         res_lin_q;
  logic signed [ASPD_W-1:0] res_ang_q;
  logic signed [HD_W-1:0]   res_err_q;
  logic                     out_load;
  logic                     out_valid_q;
  logic                     out_status_q, out_rot_q;
  logic [LIN_W-1:0]         out_lin_q;
  logic signed [ASPD_W-1:0] out_ang_q;
  logic signed [HD_W-1:0]   out_err_q;

  // ---------------------------------------------------------------------------
  // register port, always ready
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_lin_q <= LIN_W'(102);
      max_ang_q <= ASPD_W'(5734);
      look_q    <= LOOK_W'(819);
    end else if (cfg_wr) begin
      case (reg_e'(paddr[3:2]))
        REG_MAX_LIN:   max_lin_q <= pwdata[LIN_W-1:0];
        REG_MAX_ANG:   max_ang_q <= pwdata[ASPD_W-1:0];
        REG_LOOKAHEAD: look_q    <= pwdata[LOOK_W-1:0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    case (reg_e'(paddr[3:2]))
      REG_MAX_LIN:   prdata = 32'(max_lin_q);
      REG_MAX_ANG:   prdata = 32'(max_ang_q);
      REG_LOOKAHEAD: prdata = 32'(look_q);
      default:       prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // waypoint memory, written only on waypoint transfers in idle
  // ---------------------------------------------------------------------------
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign start_eff  = new_plan_i ? '0 : start_q;
  assign cnt_eff    = new_plan_i ? '0 : count_q;
  assign mem_we     = in_xfer && !op_i && (cnt_eff < CW'(PATH_DEPTH));
  assign mem_waddr  = slot_f(start_eff, cnt_eff);

  rtdpf_store #(
    .DEPTH (PATH_DEPTH),
    .AW    (AW),
    .DW    (DW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i ({pos_x_i, pos_y_i}),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  assign scan_done = (scan_i_q == count_q) && !rd_v_q && !d_v_q && !s_v_q;
  assign walk_nx   = walk_i_q + 1'b1;
  assign walk_more = walk_nx < count_q;
  assign acc_sum   = acc_q + ACC_W'(root);
  assign reached   = acc_sum >= ACC_W'(look_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    mem_re       = 1'b0;
    mem_raddr    = slot_f(start_q, scan_i_q);
    sqrt_start   = 1'b0;
    cordic_start = 1'b0;
    out_load     = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer && op_i) begin
          state_d = (count_q == '0) ? ST_DONE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        // one read per cycle, compared after the read data, difference and square registers
        mem_re = (scan_i_q < count_q);
        if (scan_done) begin
          state_d = ST_WALK_RD;
        end
      end
      ST_WALK_RD: begin
        mem_raddr = slot_f(start_q, walk_nx);
        mem_re    = walk_more;
        state_d   = walk_more ? ST_WALK_WAIT : ST_AIM;
      end
      ST_WALK_WAIT: begin
        if (s_v_q) begin
          sqrt_start = 1'b1;
          state_d    = ST_WALK_SQRT;
        end
      end
      ST_WALK_SQRT: begin
        if (sqrt_done) begin
          state_d = reached ? ST_AIM : ST_WALK_RD;
        end
      end
      ST_AIM: begin
        cordic_start = 1'b1;
        state_d      = ST_ANGLE;
      end
      ST_ANGLE: begin
        if (cordic_done) begin
          state_d = ST_STEER;
        end
      end
      ST_STEER: begin
        state_d = (flag_new && slow) ? ST_MUL : ST_DONE;
      end
      ST_MUL:   state_d = ST_DLOAD;
      ST_DLOAD: state_d = ST_DIV;
      ST_DIV:   state_d = ST_DONE;
      ST_DONE: begin
        // wait for the output register to free up
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // plan bookkeeping
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= '0;
      count_q <= '0;
    end else if (in_xfer && !op_i) begin
      start_q <= start_eff;
      if (mem_we) begin
        count_q <= cnt_eff + 1'b1;
      end else begin
        count_q <= cnt_eff;
      end
    end else if (state_q == ST_SCAN && scan_done) begin
      // drop everything ahead of the nearest waypoint
      start_q <= slot_f(start_q, near_q);
      count_q <= count_q - near_q;
    end
  end

  // ---------------------------------------------------------------------------
  // read pipeline shared by scan and walk
  // ---------------------------------------------------------------------------
  assign rd_x  = mem_rdata[DW-1 -: POS_W];
  assign rd_y  = mem_rdata[POS_W-1:0];
  assign ref_x = (state_q == ST_SCAN) ? px_q : ax_q;
  assign ref_y = (state_q == ST_SCAN) ? py_q : ay_q;
  assign dsum  = {1'b0, sqx_q} + {1'b0, sqy_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_v_q   <= 1'b0;
      d_v_q    <= 1'b0;
      s_v_q    <= 1'b0;
      scan_i_q <= '0;
    end else begin
      rd_v_q <= mem_re;
      d_v_q  <= rd_v_q;
      s_v_q  <= d_v_q;
      if (in_xfer) begin
        scan_i_q <= '0;
      end else if (state_q == ST_SCAN && mem_re) begin
        scan_i_q <= scan_i_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q <= scan_i_q;
    d_idx_q  <= rd_idx_q;
    s_idx_q  <= d_idx_q;
    dx_q     <= $signed({rd_x[POS_W-1], rd_x}) - $signed({ref_x[POS_W-1], ref_x});
    dy_q     <= $signed({rd_y[POS_W-1], rd_y}) - $signed({ref_y[POS_W-1], ref_y});
    d_x_q    <= rd_x;
    d_y_q    <= rd_y;
    sqx_q    <= unsigned'((2*DIFF_W)'(dx_q) * (2*DIFF_W)'(dx_q));
    sqy_q    <= unsigned'((2*DIFF_W)'(dy_q) * (2*DIFF_W)'(dy_q));
    s_x_q    <= d_x_q;
    s_y_q    <= d_y_q;
  end

  // pose capture, nearest search and walk registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      px_q <= pos_x_i;
      py_q <= pos_y_i;
      hd_q <= heading_i;
    end
    // first entry or strictly closer wins
    if (state_q == ST_SCAN && s_v_q && (s_idx_q == '0 || dsum < best_q)) begin
      best_q <= dsum;
      near_q <= s_idx_q;
      bx_q   <= s_x_q;
      by_q   <= s_y_q;
    end
    if (state_q == ST_SCAN && scan_done) begin
      ax_q     <= bx_q;
      ay_q     <= by_q;
      walk_i_q <= '0;
      acc_q    <= '0;
    end else if (state_q == ST_WALK_SQRT && sqrt_done) begin
      // the walked-to point becomes the segment start and the target candidate
      ax_q     <= s_x_q;
      ay_q     <= s_y_q;
      walk_i_q <= walk_nx;
      acc_q    <= acc_sum;
    end
  end

  rtdpf_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .value_i (dsum),
    .done_o  (sqrt_done),
    .root_o  (root)
  );

  assign tdx = $signed({ax_q[POS_W-1], ax_q}) - $signed({px_q[POS_W-1], px_q});
  assign tdy = $signed({ay_q[POS_W-1], ay_q}) - $signed({py_q[POS_W-1], py_q});

  rtdpf_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cordic_start),
    .dx_i    (tdx),
    .dy_i    (tdy),
    .done_o  (cordic_done),
    .angle_o (angle)
  );

  // ---------------------------------------------------------------------------
  // steering: wrap once, hysteresis, slowdown
  // ---------------------------------------------------------------------------
  always_comb begin
    raw = angle - $signed({{(ANG_W - HD_W){hd_q[HD_W-1]}}, hd_q});
    if (raw < -ANG_W'(PI_Q)) begin
      wrapped = raw + ANG_W'(TWO_PI_Q);
    end else if (raw > ANG_W'(PI_Q)) begin
      wrapped = raw - ANG_W'(TWO_PI_Q);
    end else begin
      wrapped = raw;
    end
    err = (wrapped < 0) ? unsigned'(-wrapped) : unsigned'(wrapped);
    if (flag_q) begin
      flag_new = !(err <= ANG_W'(STOP_TURN));
    end else begin
      flag_new = (err >= ANG_W'(START_TURN));
    end
    slow = err < ANG_W'(SLOW_RANGE);
    cap  = (max_ang_q < ASPD_W'(TURN_CAP)) ? max_ang_q : ASPD_W'(TURN_CAP);
    capm = $signed({1'b0, cap}) - (ASPD_W+1)'(MIN_TURN);
    err_off = err - ANG_W'(STOP_TURN);
    if (err <= ANG_W'(STOP_TURN)) begin
      n_calc = '0;
    end else if (err_off > ANG_W'(SLOW_SPAN)) begin
      n_calc = REMD_W'(SLOW_SPAN);
    end else begin
      n_calc = err_off[REMD_W-1:0];
    end
  end

  // divide by the slowdown span through a reciprocal multiply, half away from zero
  always_comb begin
    mag   = (prod_q < 0) ? DVD_W'(-prod_q) : DVD_W'(prod_q);
    mag   = mag + DVD_W'(SLOW_SPAN / 2);
    qprod = (DVD_W+RECIP_W)'(dvd_q) * (DVD_W+RECIP_W)'(RECIP);
    quot  = REMD_W'(qprod >> RECIP_SH);
    if (neg_q) begin
      spd = (ASPD_W+1)'(MIN_TURN) - $signed({2'b00, quot});
    end else begin
      spd = (ASPD_W+1)'(MIN_TURN) + $signed({2'b00, quot});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_q <= 1'b0;
    end else if (state_q == ST_STEER) begin
      flag_q <= flag_new;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        // empty plan answers with error status and zero fields
        res_status_q <= 1'b1;
        res_lin_q    <= '0;
        res_ang_q    <= '0;
        res_err_q    <= '0;
      end
      ST_STEER: begin
        res_status_q <= 1'b0;
        res_err_q    <= wrapped[HD_W-1:0];
        diff_pos_q   <= wrapped > 0;
        n_q          <= n_calc;
        capm_q       <= capm;
        if (!flag_new) begin
          res_lin_q <= max_lin_q;
          res_ang_q <= '0;
        end else begin
          res_lin_q <= '0;
          res_ang_q <= (wrapped > 0) ? -$signed(cap) : $signed(cap);
        end
      end
      ST_MUL: begin
        prod_q <= PROD_W'($signed({1'b0, n_q}) * capm_q);
      end
      ST_DLOAD: begin
        neg_q <= prod_q < 0;
        dvd_q <= mag;
      end
      ST_DIV: begin
        res_ang_q <= diff_pos_q ? ASPD_W'(-spd) : ASPD_W'(spd);
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_status_q <= res_status_q;
      out_lin_q    <= res_lin_q;
      out_ang_q    <= res_ang_q;
      out_rot_q    <= flag_q;
      out_err_q    <= res_err_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign linear_speed_o  = out_lin_q;
  assign angular_speed_o = out_ang_q;
  assign rotating_o      = out_rot_q;
  assign heading_error_o = out_err_q;

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(PATH_DEPTH))
    else $error("plan count beyond ring depth");

  a_sqrt_when_walking: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sqrt_done |-> state_q == ST_WALK_SQRT)
    else $error("square root finished outside the walk");

  a_cordic_when_aiming: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cordic_done |-> state_q == ST_ANGLE)
    else $error("angle finished outside the angle step");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_DONE)
    else $error("result appeared without a finished pose");

  a_write_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == ST_IDLE && !mem_re))
    else $error("waypoint write overlaps a pose read");

endmodule

FILE: tb/tb_rotate_then_drive_path_follower_top.sv
// testbench for the rotate-then-drive path follower: predictor scoreboard and stimulus
module tb_rotate_then_drive_path_follower_top;
  import rtdpf_pkg::*;

  // one command as seen on the result channel
  typedef struct packed {
    logic              status;
    logic [LIN_W-1:0]  lin;
    logic [ASPD_W-1:0] ang;
    logic              rot;
    logic [HD_W-1:0]   herr;
  } command_t;

  // ring-buffer plan store and steering predictor with its own copy of the registers
  class follower_scoreboard;
    logic signed [POS_W-1:0] path_x[PATH_DEPTH_DEF];
    logic signed [POS_W-1:0] path_y[PATH_DEPTH_DEF];
    int unsigned path_head, path_len;
    bit          turning;
    int unsigned lin_limit, ang_limit, look_dist;
    command_t    pending_cmds[$];
    int          errors;
    longint      arctan_steps[16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                                      256, 128, 64, 32, 16, 8, 4, 2};

    function new();
      path_head = 0;
      path_len  = 0;
      turning   = 0;
      lin_limit = 102;
      ang_limit = 5734;
      look_dist = 819;
      errors    = 0;
    endfunction

    function void set_reg(reg_e r, int unsigned v);
      case (r)
        REG_MAX_LIN:   lin_limit = v & 12'hFFF;
        REG_MAX_ANG:   ang_limit = v & 14'h3FFF;
        REG_LOOKAHEAD: look_dist = v & 16'hFFFF;
        default: ;
      endcase
    endfunction

    function int unsigned ring_slot(int unsigned i);
      return (path_head + i) % PATH_DEPTH_DEF;
    endfunction

    function longint unsigned seg_length(longint unsigned v);
      longint unsigned res, bitv;
      res  = 0;
      bitv = 64'h1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
        if (v >= res + bitv) begin
          v   -= res + bitv;
          res  = (res >> 1) + bitv;
        end else begin
          res >>= 1;
        end
        bitv >>= 2;
      end
      return res;
    endfunction

    // cordic vectoring, result in 1/8192 rad
    function longint bearing(longint dx, longint dy);
      longint base, z, nx, ny;
      base = 0;
      z    = 0;
      if (dy == 0) return (dx < 0) ? PI_Q : 0;
      if (dx < 0) begin
        base = (dy > 0) ? PI_FINE : -PI_FINE;
        dx = -dx;
        dy = -dy;
      end
      for (int i = 0; i < 16; i++) begin
        if (dy > 0) begin
          nx = dx + (dy >>> i);
          ny = dy - (dx >>> i);
          z += arctan_steps[i];
        end else begin
          nx = dx - (dy >>> i);
          ny = dy + (dx >>> i);
          z -= arctan_steps[i];
        end
        dx = nx;
        dy = ny;
      end
      return (base + z + 4) >>> 3;
    endfunction

    function void note_input(logic op, logic np, logic signed [POS_W-1:0] x,
                             logic signed [POS_W-1:0] y, logic signed [HD_W-1:0] h);
      int unsigned closest, tgt, s, a, b;
      longint px, py, dx, dy, diff, err, lin, ang, cap, spd, n, prod, q;
      longint unsigned best, d, acc;
      command_t c;
      px = longint'(x);
      py = longint'(y);
      if (op == 1'b0) begin
        if (np) begin
          path_head = 0;
          path_len  = 0;
        end
        if (path_len < PATH_DEPTH_DEF) begin
          s = ring_slot(path_len);
          path_x[s] = x;
          path_y[s] = y;
          path_len++;
        end
        return;
      end
      if (path_len == 0) begin
        c = '{status: 1'b1, lin: '0, ang: '0, rot: turning, herr: '0};
        pending_cmds.push_back(c);
        return;
      end
      tgt = path_len - 1;
      closest = 0;
      if (path_len >= 2) begin
        best = 0;
        acc  = 0;
        for (int unsigned i = 0; i < path_len; i++) begin
          s  = ring_slot(i);
          dx = longint'(path_x[s]) - px;
          dy = longint'(path_y[s]) - py;
          d  = longint'(dx * dx) + longint'(dy * dy);
          if (i == 0 || d < best) begin
            best = d;
            closest = i;
          end
        end
        tgt = closest;
        for (int unsigned i = closest; i + 1 < path_len; i++) begin
          a  = ring_slot(i);
          b  = ring_slot(i + 1);
          dx = longint'(path_x[b]) - longint'(path_x[a]);
          dy = longint'(path_y[b]) - longint'(path_y[a]);
          acc += seg_length(dx * dx + dy * dy);
          if (acc >= look_dist) begin
            tgt = i + 1;
            break;
          end
        end
        if (tgt == closest) tgt = path_len - 1;
        path_head = ring_slot(closest);
        path_len -= closest;
        tgt -= closest;
      end
      s = ring_slot(tgt);
      diff = bearing(longint'(path_x[s]) - px, longint'(path_y[s]) - py) - longint'(h);
      if (diff < -PI_Q) diff += TWO_PI_Q;
      else if (diff > PI_Q) diff -= TWO_PI_Q;
      err = (diff < 0) ? -diff : diff;
      if (turning) begin
        if (err <= STOP_TURN) turning = 0;
      end else begin
        if (err >= START_TURN) turning = 1;
      end
      lin = 0;
      ang = 0;
      if (turning) begin
        cap = (ang_limit < TURN_CAP) ? ang_limit : TURN_CAP;
        spd = cap;
        if (err < SLOW_RANGE) begin
          n = err - STOP_TURN;
          if (n < 0) n = 0;
          if (n > SLOW_SPAN) n = SLOW_SPAN;
          prod = n * (cap - MIN_TURN);
          q = (prod >= 0) ? (prod + SLOW_SPAN / 2) / SLOW_SPAN
                          : -((-prod + SLOW_SPAN / 2) / SLOW_SPAN);
          spd = MIN_TURN + q;
        end
        ang = (diff > 0) ? -spd : spd;
      end else begin
        lin = lin_limit;
      end
      c.status = 1'b0;
      c.lin    = lin[LIN_W-1:0];
      c.ang    = ang[ASPD_W-1:0];
      c.rot    = turning;
      c.herr   = diff[HD_W-1:0];
      pending_cmds.push_back(c);
    endfunction

    task report_mismatch(string what, longint got, longint want);
      $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
      errors++;
    endtask

    task check_result(command_t r);
      command_t e;
      if (pending_cmds.size() == 0) begin
        report_mismatch("command with nothing pending, status", r.status, -1);
        return;
      end
      e = pending_cmds.pop_front();
      if (r.status !== e.status) report_mismatch("status", r.status, e.status);
      if (r.lin !== e.lin) report_mismatch("linear_speed", r.lin, e.lin);
      if (r.ang !== e.ang)
        report_mismatch("angular_speed", $signed(r.ang), $signed(e.ang));
      if (r.rot !== e.rot) report_mismatch("rotating", r.rot, e.rot);
      if (r.herr !== e.herr)
        report_mismatch("heading_error", $signed(r.herr), $signed(e.herr));
    endtask
  endclass

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     in_valid_i = 1'b0;
  logic                     in_stall_o;
  logic                     op_i = 1'b0;
  logic                     new_plan_i = 1'b0;
  logic signed [POS_W-1:0]  pos_x_i = '0;
  logic signed [POS_W-1:0]  pos_y_i = '0;
  logic signed [HD_W-1:0]   heading_i = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic                     status_o;
  logic [LIN_W-1:0]         linear_speed_o;
  logic signed [ASPD_W-1:0] angular_speed_o;
  logic                     rotating_o;
  logic signed [HD_W-1:0]   heading_error_o;
  logic                     psel = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite = 1'b0;
  logic [3:0]               paddr = '0;
  logic [31:0]              pwdata = '0;
  logic [31:0]              prdata;
  logic                     pready;

  follower_scoreboard sb = new();

  // idling percentages of the current phase, and the long receiver hold-off
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;

  // last plan offered, used to aim poses near the path
  int plan_xs[$];
  int plan_ys[$];

  rotate_then_drive_path_follower_top uut (.*);

  // 4-unit clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // receiver: stall decided on the falling edge, long hold-off counted here
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        out_stall_i = 1'b1;
        hold_left--;
      end else begin
        out_stall_i = ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // every accepted result transfer is checked against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result('{status: status_o, lin: linear_speed_o, ang: angular_speed_o,
                        rot: rotating_o, herr: heading_error_o});
  end

  // offer one item; valid stays high across back-to-back transfers
  task automatic send_item(input logic op, input logic np, input int x, input int y,
                           input int h);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    op_i       = op;
    new_plan_i = np;
    pos_x_i    = x[POS_W-1:0];
    pos_y_i    = y[POS_W-1:0];
    heading_i  = h[HD_W-1:0];
    forever begin
      @(posedge clk_i);
      if (!in_stall_o) break;
    end
    sb.note_input(op_i, new_plan_i, pos_x_i, pos_y_i, heading_i);
  endtask

  task automatic end_offer();
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  // wait for every predicted command, then let the block settle before a register write
  task automatic drain();
    end_offer();
    while (sb.pending_cmds.size() != 0) @(posedge clk_i);
    repeat (64) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_e r, input int unsigned v);
    @(negedge clk_i);
    psel    = 1'b1;
    pwrite  = 1'b1;
    penable = 1'b0;
    paddr   = {r, 2'b00};
    pwdata  = v;
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    sb.set_reg(r, v);
  endtask

  task automatic send_waypoint(input logic np, input int x, input int y);
    if (np) begin
      plan_xs.delete();
      plan_ys.delete();
    end
    plan_xs.push_back(x);
    plan_ys.push_back(y);
    send_item(1'b0, np, x, y, $urandom);
  endtask

  // fresh plan: a wandering polyline, sometimes spread over the full coordinate range
  task automatic send_plan(input int len, input bit wide);
    int x, y, step;
    step = wide ? 2000000 : $urandom_range(100, 2500);
    x = wide ? $urandom : $signed($urandom_range(0, 200000)) - 100000;
    y = wide ? $urandom : $signed($urandom_range(0, 200000)) - 100000;
    for (int i = 0; i < len; i++) begin
      send_waypoint(i == 0, (x <<< 8) >>> 8, (y <<< 8) >>> 8);
      x += $signed($urandom_range(0, 2 * step)) - step;
      y += $signed($urandom_range(0, 2 * step)) - step;
    end
  endtask

  // pose near some waypoint of the current plan, heading mostly in range
  task automatic send_pose();
    int k, x, y, h, off;
    off = $urandom_range(0, 3) == 0 ? 100000 : 1500;
    if (plan_xs.size() != 0) begin
      k = $urandom_range(0, plan_xs.size() - 1);
      x = plan_xs[k] + $signed($urandom_range(0, 2 * off)) - off;
      y = plan_ys[k] + $signed($urandom_range(0, 2 * off)) - off;
    end else begin
      x = $urandom;
      y = $urandom;
    end
    h = ($urandom_range(0, 4) == 0) ? $signed($urandom_range(0, 65535)) - 32768
                                    : $signed($urandom_range(0, 2 * PI_Q)) - PI_Q;
    send_item(1'b1, $urandom_range(0, 1), (x <<< 8) >>> 8, (y <<< 8) >>> 8, h);
  endtask

  task automatic random_batch(input int items);
    int done, len;
    done = 0;
    while (done < items) begin
      case ($urandom_range(0, 9))
        0: begin
          len = $urandom_range(2, 20);
          send_plan(len, $urandom_range(0, 3) == 0);
          done += len;
        end
        1: begin
          // noise: a stray waypoint appended to the current plan
          send_waypoint(1'b0, (int'($urandom) <<< 8) >>> 8, (int'($urandom) <<< 8) >>> 8);
          done++;
        end
        default: begin
          send_pose();
          done++;
        end
      endcase
    end
  endtask

  // stimulus
  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: empty plan, single waypoint, extremes, target line cases
    send_item(1'b1, 1'b0, 0, 0, 0);
    send_waypoint(1'b1, -8388608, 8388607);
    send_item(1'b1, 1'b0, -8388608, 8388607, 0);
    send_item(1'b1, 1'b1, 8388607, -8388608, -32768);
    send_waypoint(1'b1, 1000, 0);
    send_waypoint(1'b0, 3000, 0);
    send_waypoint(1'b0, 5000, 0);
    send_item(1'b1, 1'b0, 0, 0, 0);
    send_item(1'b1, 1'b0, 9000, 0, 0);
    send_item(1'b1, 1'b0, 5000, 0, 32767);
    send_item(1'b1, 1'b0, 4000, 500, 25736);
    send_item(1'b1, 1'b0, 4000, -500, -25736);
    send_item(1'b1, 1'b0, 4000, 0, 1000);
    send_item(1'b1, 1'b0, 4000, 0, 300);
    send_item(1'b1, 1'b0, 4000, 0, -2000);
    send_waypoint(1'b1, 0, 0);
    send_waypoint(1'b0, 8388607, 8388607);
    send_item(1'b1, 1'b0, -8388608, -8388608, 12345);
    drain();

    // phase: no idling, extreme registers
    write_reg(REG_MAX_LIN, 4095);
    write_reg(REG_MAX_ANG, 16383);
    write_reg(REG_LOOKAHEAD, 0);
    random_batch(20);
    drain();

    // phase: sender idles, small turn speed below the slowdown floor
    send_idle_pct = 47;
    write_reg(REG_MAX_LIN, 0);
    write_reg(REG_MAX_ANG, 0);
    write_reg(REG_LOOKAHEAD, 65535);
    random_batch(20);
    drain();

    // phase: receiver stalls, with one long hold-off while poses keep coming
    send_idle_pct = 0;
    recv_stall_pct = 47;
    write_reg(REG_MAX_LIN, $urandom_range(0, 4095));
    write_reg(REG_MAX_ANG, $urandom_range(0, 16383));
    write_reg(REG_LOOKAHEAD, $urandom_range(0, 5000));
    send_plan(4, 1'b0);
    @(posedge clk_i);
    hold_left = 600;
    random_batch(20);
    drain();

    // phase: both sides idle, reset values restored
    send_idle_pct = 28;
    recv_stall_pct = 28;
    write_reg(REG_MAX_LIN, 102);
    write_reg(REG_MAX_ANG, 5734);
    write_reg(REG_LOOKAHEAD, 819);
    random_batch(20);
    drain();

    while (sb.pending_cmds.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // guard against a hung handshake
  initial begin
    #8000000;
    $display("simulation failed");
    $finish;
  end

endmodule
